// File: rtl/fqd_pkg.sv
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types, result codes and the hex digit decoder for the form query
// decoder.
// ----------------------------------------------------------------------------
package fqd_pkg;

	typedef enum logic [2:0] {
		KIND_NAME_CHAR  = 3'd0,
		KIND_VALUE_CHAR = 3'd1,
		KIND_NAME_END   = 3'd2,
		KIND_PAIR_END   = 3'd3,
		KIND_ERROR      = 3'd4,
		KIND_QUERY_END  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_HIGH = 2'd1,
		ESC_LOW  = 2'd2,
		ESC_XTRA = 2'd3
	} esc_phase_t;

	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_PLUS    = 8'h2b;
	localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
	localparam logic [7:0] CHAR_AMP     = 8'h26;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] OFS_DIGIT    = 8'h30;
	localparam logic [7:0] OFS_UPPER    = 8'h37;
	localparam logic [7:0] OFS_LOWER    = 8'h57;
	localparam logic [7:0] SPAN_ALPHA   = 8'h05;
	localparam logic [7:0] SPAN_DIGIT   = 8'h09;

	// one queue entry holds all results of one input word (1 to 3)
	typedef struct packed {
		logic [1:0]  cnt;
		kind_t       k0;
		logic [7:0]  ch0;
		kind_t       k1;
		kind_t       k2;
	} entry_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		logic [7:0] u;
		logic [7:0] l;
		d = c - OFS_DIGIT;
		u = c - (OFS_UPPER + 8'h0a);
		l = c - (OFS_LOWER + 8'h0a);
		if (d <= SPAN_DIGIT) begin
			hex_value = {1'b1, d[3:0]};
		end else if (u <= SPAN_ALPHA) begin
			hex_value = {1'b1, 4'(c - OFS_UPPER)};
		end else if (l <= SPAN_ALPHA) begin
			hex_value = {1'b1, 4'(c - OFS_LOWER)};
		end else begin
			hex_value = 5'd0;
		end
	endfunction

endpackage

// File: rtl/fqd_in_if.sv
// ----------------------------------------------------------------------------
// fqd_in_if
// Query byte channel: valid/ready handshake with one raw byte and its end mark.
// ----------------------------------------------------------------------------
interface fqd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/fqd_out_if.sv
// ----------------------------------------------------------------------------
// fqd_out_if
// Result channel: valid/ready handshake with one decoded result word.
// ----------------------------------------------------------------------------
interface fqd_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] decoded_char;
	logic       run_end;

	modport source (output valid, output kind, output decoded_char, output run_end,
		input ready);
	modport sink   (input valid, input kind, input decoded_char, input run_end,
		output ready);
endinterface

// File: rtl/fqd_front.sv
// ----------------------------------------------------------------------------
// fqd_front
// Accepts query bytes, tracks parse state and packs the results of each byte
// into one queue entry.
// ----------------------------------------------------------------------------
module fqd_front (
	input  logic            clk,
	input  logic            arst_n,
	fqd_in_if.sink          query,
	input  logic            q_full,
	output logic            push,
	output fqd_pkg::entry_t push_entry
);

	logic                   in_value_q;
	fqd_pkg::esc_phase_t    esc_q;
	logic [3:0]             high_nibble_q;
	logic                   name_nonempty_q;
	logic                   discarding_q;

	logic                   in_value_nx;
	fqd_pkg::esc_phase_t    esc_nx;
	logic [3:0]             high_nibble_nx;
	logic                   name_nonempty_nx;
	logic                   discarding_nx;

	logic                   accept;
	logic [7:0]             c;
	logic                   last;
	logic [4:0]             hex;
	fqd_pkg::kind_t         chk;
	logic                   err;
	logic                   closed;
	logic                   clear;
	logic                   p_valid;
	fqd_pkg::kind_t         p_kind;
	logic [7:0]             p_char;
	logic [1:0]             tn;
	fqd_pkg::kind_t         t1;
	fqd_pkg::kind_t         t2;

	assign query.ready = !q_full;
	assign accept      = query.valid && !q_full;
	assign c           = query.data_byte;
	assign last        = query.last_byte;
	assign hex         = fqd_pkg::hex_value(c);
	assign chk         = in_value_q ? fqd_pkg::KIND_VALUE_CHAR : fqd_pkg::KIND_NAME_CHAR;

	always_comb begin
		in_value_nx      = in_value_q;
		esc_nx           = esc_q;
		high_nibble_nx   = high_nibble_q;
		name_nonempty_nx = name_nonempty_q;
		discarding_nx    = discarding_q;
		err              = 1'b0;
		closed           = 1'b0;
		clear            = 1'b0;
		p_valid          = 1'b0;
		p_kind           = chk;
		p_char           = 8'h00;
		tn               = 2'd0;
		t1               = fqd_pkg::KIND_PAIR_END;
		t2               = fqd_pkg::KIND_QUERY_END;
		push_entry       = '0;
		push             = 1'b0;

		if (discarding_q) begin
			clear = last;
		end else begin
			priority if (esc_q == fqd_pkg::ESC_HIGH) begin
				if (!hex[4]) begin
					err = 1'b1;
				end else begin
					high_nibble_nx = hex[3:0];
					esc_nx         = fqd_pkg::ESC_LOW;
				end
			end else if (esc_q != fqd_pkg::ESC_NONE) begin
				if (!hex[4]) begin
					err = 1'b1;
				end else begin
					p_valid = 1'b1;
					p_char  = {high_nibble_q, hex[3:0]};
					esc_nx  = fqd_pkg::ESC_NONE;
					if (!in_value_q)
						name_nonempty_nx = 1'b1;
				end
			end else if (c == fqd_pkg::CHAR_PERCENT) begin
				esc_nx = fqd_pkg::ESC_HIGH;
			end else if (!in_value_q && c == fqd_pkg::CHAR_EQUALS) begin
				if (!name_nonempty_q) begin
					err = 1'b1;
				end else begin
					p_valid     = 1'b1;
					p_kind      = fqd_pkg::KIND_NAME_END;
					in_value_nx = 1'b1;
				end
			end else if (in_value_q && c == fqd_pkg::CHAR_AMP) begin
				p_valid          = 1'b1;
				p_kind           = fqd_pkg::KIND_PAIR_END;
				in_value_nx      = 1'b0;
				name_nonempty_nx = 1'b0;
				closed           = 1'b1;
			end else begin
				p_valid = 1'b1;
				p_char  = (c == fqd_pkg::CHAR_PLUS) ? fqd_pkg::CHAR_SPACE : c;
				if (!in_value_q)
					name_nonempty_nx = 1'b1;
			end

			if (!err && last) begin
				priority if (esc_nx != fqd_pkg::ESC_NONE) begin
					err = 1'b1;
				end else if (closed) begin
					tn    = 2'd1;
					t1    = fqd_pkg::KIND_QUERY_END;
					clear = 1'b1;
				end else if (!in_value_nx) begin
					err = 1'b1;
				end else begin
					tn    = 2'd2;
					clear = 1'b1;
				end
			end

			if (err) begin
				clear         = 1'b1;
				push          = accept;
				push_entry.cnt = 2'd1;
				push_entry.k0  = fqd_pkg::KIND_ERROR;
				push_entry.ch0 = 8'h00;
				push_entry.k1  = fqd_pkg::KIND_ERROR;
				push_entry.k2  = fqd_pkg::KIND_ERROR;
			end else if (p_valid) begin
				push           = accept;
				push_entry.cnt = 2'({1'b0, p_valid} + tn);
				push_entry.k0  = p_kind;
				push_entry.ch0 = p_char;
				push_entry.k1  = t1;
				push_entry.k2  = t2;
			end else begin
				push           = accept && (tn != 2'd0);
				push_entry.cnt = tn;
				push_entry.k0  = t1;
				push_entry.ch0 = 8'h00;
				push_entry.k1  = t2;
				push_entry.k2  = t2;
			end
		end

		if (clear) begin
			in_value_nx      = 1'b0;
			esc_nx           = fqd_pkg::ESC_NONE;
			high_nibble_nx   = 4'd0;
			name_nonempty_nx = 1'b0;
			discarding_nx    = 1'b0;
		end
		// error not on the last word: drop until the last word
		if (!discarding_q && err && !last)
			discarding_nx = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_value_q      <= 1'b0;
			esc_q           <= fqd_pkg::ESC_NONE;
			high_nibble_q   <= 4'd0;
			name_nonempty_q <= 1'b0;
			discarding_q    <= 1'b0;
		end else if (accept) begin
			in_value_q      <= in_value_nx;
			esc_q           <= esc_nx;
			high_nibble_q   <= high_nibble_nx;
			name_nonempty_q <= name_nonempty_nx;
			discarding_q    <= discarding_nx;
		end
	end

endmodule

// File: rtl/fqd_queue.sv
// ----------------------------------------------------------------------------
// fqd_queue
// Small FIFO of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module fqd_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fqd_pkg::entry_t push_entry,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output fqd_pkg::entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fqd_pkg::entry_t mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign head    = mem[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= CW'(count_q + 1'b1);
			else if (do_pop && !do_push)
				count_q <= CW'(count_q - 1'b1);
		end
	end

endmodule

// File: rtl/fqd_back.sv
// ----------------------------------------------------------------------------
// fqd_back
// Unpacks queue entries into single result words behind an output register.
// ----------------------------------------------------------------------------
module fqd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  fqd_pkg::entry_t head,
	output logic            pop,
	fqd_out_if.source       result
);

	logic           res_valid_q;
	fqd_pkg::kind_t res_kind_q;
	logic [7:0]     res_char_q;
	logic           res_end_q;
	logic [1:0]     sub_q;

	logic           load;
	logic           sub_last;
	fqd_pkg::kind_t sel_kind;

	assign load     = !q_empty && (!res_valid_q || result.ready);
	assign sub_last = (2'(sub_q + 2'd1) == head.cnt);
	assign pop      = load && sub_last;

	always_comb begin
		unique case (sub_q)
			2'd0:    sel_kind = head.k0;
			2'd1:    sel_kind = head.k1;
			default: sel_kind = head.k2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			sub_q       <= 2'd0;
		end else if (load) begin
			res_valid_q <= 1'b1;
			sub_q       <= sub_last ? 2'd0 : 2'(sub_q + 2'd1);
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_kind_q <= sel_kind;
			res_char_q <= (sub_q == 2'd0) ? head.ch0 : 8'h00;
			res_end_q  <= sub_last;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.kind         = res_kind_q;
	assign result.decoded_char = res_char_q;
	assign result.run_end      = res_end_q;

endmodule

// File: rtl/form_query_decoder_core.sv
// ----------------------------------------------------------------------------
// form_query_decoder_core
// Streaming decoder for form-urlencoded query bytes.
// An accepted byte's results are written to the entry queue, then unpacked into the output register.
// Throughput: one byte per cycle while the queue is not full; the result port moves one word per cycle
// while result ready is high, so a byte that gives two or three results holds that port for as long.
// Reset clears parse state, the entry queue and the output register.
// ----------------------------------------------------------------------------
module form_query_decoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	fqd_in_if.sink    query,
	fqd_out_if.source result
);

	logic            q_full;
	logic            q_empty;
	logic            push;
	logic            pop;
	fqd_pkg::entry_t push_entry;
	fqd_pkg::entry_t head;

	fqd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.query      (query),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	fqd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (head)
	);

	fqd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.result  (result)
	);

endmodule

// File: dv/fqd_decode_checker.sv
// ----------------------------------------------------------------------------
// fqd_decode_checker
// Watches the query byte and result channels of the form query decoder.
// Each accepted byte is decoded by an independent parser, and the words it
// should produce are queued. Each accepted result word is compared, field by
// field, with the oldest queued word. It reports the running failure count
// and the number of words still due.
// ----------------------------------------------------------------------------
module fqd_decode_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_data,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [2:0] out_kind,
	input  logic [7:0] out_char,
	input  logic       out_end,
	output int         fail_count,
	output int         pending
);

	typedef struct {
		fqd_pkg::kind_t kind;
		logic [7:0]     ch;
		logic           run_end;
	} result_word_t;

	result_word_t words_due[$];
	result_word_t due;

	// parser state
	logic                in_value;
	fqd_pkg::esc_phase_t esc;
	logic [3:0]          hi_nib;
	logic                name_seen;
	logic                dropping;
	int                  errors;

	task automatic clear_parse();
		in_value  = 1'b0;
		esc       = fqd_pkg::ESC_NONE;
		hi_nib    = 4'h0;
		name_seen = 1'b0;
		dropping  = 1'b0;
	endtask

	// {is_hex, nibble}
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return {1'b1, 4'(c - "0")};
		end else if (c >= "A" && c <= "F") begin
			return {1'b1, 4'(c - "A" + 8'd10)};
		end else if (c >= "a" && c <= "f") begin
			return {1'b1, 4'(c - "a" + 8'd10)};
		end
		return 5'd0;
	endfunction

	task automatic decode_byte(input logic [7:0] c, input logic fin);
		result_word_t   run[$];
		logic           err;
		logic           closed;
		fqd_pkg::kind_t char_kind;
		logic [4:0]     nib;
		err       = 1'b0;
		closed    = 1'b0;
		char_kind = in_value ? fqd_pkg::KIND_VALUE_CHAR : fqd_pkg::KIND_NAME_CHAR;
		nib       = nibble_of(c);
		if (dropping) begin
			// swallow everything after an error until the query ends
			if (fin) clear_parse();
			return;
		end
		if (esc == fqd_pkg::ESC_HIGH) begin
			if (!nib[4]) begin
				err = 1'b1;
			end else begin
				hi_nib = nib[3:0];
				esc    = fqd_pkg::ESC_LOW;
			end
		end else if (esc != fqd_pkg::ESC_NONE) begin
			if (!nib[4]) begin
				err = 1'b1;
			end else begin
				run.push_back('{char_kind, {hi_nib, nib[3:0]}, 1'b0});
				esc = fqd_pkg::ESC_NONE;
				if (!in_value) name_seen = 1'b1;
			end
		end else if (c == fqd_pkg::CHAR_PERCENT) begin
			esc = fqd_pkg::ESC_HIGH;
		end else if (!in_value && c == fqd_pkg::CHAR_EQUALS) begin
			if (!name_seen) begin
				err = 1'b1;
			end else begin
				run.push_back('{fqd_pkg::KIND_NAME_END, 8'h00, 1'b0});
				in_value = 1'b1;
			end
		end else if (in_value && c == fqd_pkg::CHAR_AMP) begin
			run.push_back('{fqd_pkg::KIND_PAIR_END, 8'h00, 1'b0});
			in_value  = 1'b0;
			name_seen = 1'b0;
			closed    = 1'b1;
		end else begin
			run.push_back('{char_kind,
				(c == fqd_pkg::CHAR_PLUS) ? fqd_pkg::CHAR_SPACE : c, 1'b0});
			if (!in_value) name_seen = 1'b1;
		end

		if (!err && fin) begin
			if (esc != fqd_pkg::ESC_NONE) begin
				err = 1'b1;
			end else if (closed) begin
				run.push_back('{fqd_pkg::KIND_QUERY_END, 8'h00, 1'b0});
				clear_parse();
			end else if (!in_value) begin
				err = 1'b1;
			end else begin
				run.push_back('{fqd_pkg::KIND_PAIR_END, 8'h00, 1'b0});
				run.push_back('{fqd_pkg::KIND_QUERY_END, 8'h00, 1'b0});
				clear_parse();
			end
		end

		if (err) begin
			run.delete();
			run.push_back('{fqd_pkg::KIND_ERROR, 8'h00, 1'b0});
			clear_parse();
			dropping = !fin;
		end

		if (run.size() > 0) begin
			run[run.size() - 1].run_end = 1'b1;
			foreach (run[i]) words_due.push_back(run[i]);
		end
	endtask

	initial begin
		clear_parse();
		errors     = 0;
		fail_count = 0;
		pending    = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) decode_byte(in_data, in_last);
			if (out_valid && out_ready) begin
				if (words_due.size() == 0) begin
					$error("result word with none due: kind=%0d decoded_char=%0h run_end=%0b",
						out_kind, out_char, out_end);
					errors++;
				end else begin
					due = words_due.pop_front();
					if (out_kind !== due.kind) begin
						$error("kind: expected %0d, got %0d", due.kind, out_kind);
						errors++;
					end
					if (out_char !== due.ch) begin
						$error("decoded_char: expected %0h, got %0h", due.ch, out_char);
						errors++;
					end
					if (out_end !== due.run_end) begin
						$error("run_end: expected %0b, got %0b", due.run_end, out_end);
						errors++;
					end
				end
			end
			fail_count <= errors;
			pending    <= words_due.size();
		end
	end

endmodule

// File: dv/tb_form_query_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_form_query_decoder_core
// Drives query strings into form_query_decoder_core: a few hand-picked
// queries for escapes, separators and error paths, then random queries,
// mostly well formed with some corrupted or pure noise. Bytes go out in
// bursts with random gaps while the result side stalls on its own pattern.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_form_query_decoder_core;

	localparam int BYTE_TARGET = 270;
	localparam int IDLE_LIMIT  = 2000;
	localparam int TAIL_CYCLES = 12;

	typedef enum {RX_OPEN, RX_COIN, RX_COMB, RX_HOLD} rx_mode_t;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   bytes_sent;
	int   burst_left;
	int   idle_cycles;

	logic [7:0] query_bytes[$];

	string directed_text[8] = '{
		"%41+=%Ff",  // escapes of both cases, plus, top byte value
		"&=x&",      // amp inside a name, query closed by amp
		"=",         // empty name
		"a",         // name with no equals at end of query
		"b=",        // end right after equals
		"%4",        // truncated escape
		"%g1",       // bad escape digit, rest dropped
		"c=="        // equals inside a value
	};

	fqd_in_if  query_bus();
	fqd_out_if result_bus();

	form_query_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_bus),
		.result (result_bus)
	);

	fqd_decode_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (query_bus.valid),
		.in_ready   (query_bus.ready),
		.in_data    (query_bus.data_byte),
		.in_last    (query_bus.last_byte),
		.out_valid  (result_bus.valid),
		.out_ready  (result_bus.ready),
		.out_kind   (result_bus.kind),
		.out_char   (result_bus.decoded_char),
		.out_end    (result_bus.run_end),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// result side: stall pattern is redrawn at random whenever its stretch runs out
	initial begin
		rx_mode_t mode;
		int       stretch;
		int       tick;
		mode    = RX_OPEN;
		stretch = 0;
		tick    = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				mode    = rx_mode_t'($urandom_range(0, 3));
				stretch = (mode == RX_HOLD) ? $urandom_range(1, 24) : $urandom_range(5, 40);
			end
			stretch--;
			tick++;
			case (mode)
				RX_OPEN: result_bus.ready <= 1'b1;
				RX_COIN: result_bus.ready <= 1'($urandom_range(0, 1));
				RX_COMB: result_bus.ready <= (tick % 3 != 0);
				default: result_bus.ready <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((query_bus.valid && query_bus.ready) || (result_bus.valid && result_bus.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			query_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		query_bus.valid     <= 1'b1;
		query_bus.data_byte <= b;
		query_bus.last_byte <= fin;
		do @(posedge clk); while (!query_bus.ready);
		bytes_sent++;
	endtask

	task automatic send_query();
		foreach (query_bytes[i]) put_byte(query_bytes[i], i == query_bytes.size() - 1);
	endtask

	// hold the sender until every due result word has arrived
	task automatic drain();
		@(negedge clk);
		query_bus.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'("0") + n;
		return (($urandom_range(0, 1) == 1) ? 8'("A") : 8'("a")) + n - 8'd10;
	endfunction

	function automatic void add_char(input logic in_val);
		logic [7:0] b;
		logic [7:0] v;
		case ($urandom_range(0, 9))
			0, 1: begin
				v = 8'($urandom_range(0, 255));
				query_bytes.push_back(fqd_pkg::CHAR_PERCENT);
				query_bytes.push_back(hex_char(v[7:4]));
				query_bytes.push_back(hex_char(v[3:0]));
			end
			2: query_bytes.push_back(fqd_pkg::CHAR_PLUS);
			3, 4, 5: query_bytes.push_back(8'("a") + 8'($urandom_range(0, 25)));
			default: begin
				do b = 8'($urandom_range(0, 255));
				while (b == fqd_pkg::CHAR_PERCENT ||
					b == (in_val ? fqd_pkg::CHAR_AMP : fqd_pkg::CHAR_EQUALS));
				query_bytes.push_back(b);
			end
		endcase
	endfunction

	function automatic void build_query();
		int pairs;
		query_bytes.delete();
		pairs = $urandom_range(1, 4);
		for (int p = 0; p < pairs; p++) begin
			if (p > 0) query_bytes.push_back(fqd_pkg::CHAR_AMP);
			repeat ($urandom_range(1, 4)) add_char(1'b0);
			query_bytes.push_back(fqd_pkg::CHAR_EQUALS);
			repeat ($urandom_range(0, 4)) add_char(1'b1);
		end
		if ($urandom_range(0, 4) == 0) query_bytes.push_back(fqd_pkg::CHAR_AMP);
	endfunction

	function automatic void corrupt_query();
		int         idx;
		logic [7:0] bad[4];
		idx = $urandom_range(0, query_bytes.size() - 1);
		bad = '{fqd_pkg::CHAR_AMP, fqd_pkg::CHAR_EQUALS, 8'("G"),
			8'($urandom_range(8'h80, 8'hff))};
		case ($urandom_range(0, 4))
			0: query_bytes[idx] = 8'($urandom_range(0, 255));
			1: query_bytes = query_bytes[0:idx];
			2: begin
				query_bytes.insert(idx, bad[$urandom_range(0, 3)]);
				query_bytes.insert(idx, fqd_pkg::CHAR_PERCENT);
			end
			3: begin
				foreach (query_bytes[i]) begin
					if (query_bytes[i] == fqd_pkg::CHAR_EQUALS) begin
						query_bytes.delete(i);
						break;
					end
				end
			end
			default: begin
				if ($urandom_range(0, 1) == 1) query_bytes.push_front(fqd_pkg::CHAR_EQUALS);
				else query_bytes.push_back(fqd_pkg::CHAR_PERCENT);
			end
		endcase
	endfunction

	initial begin
		arst_n              = 1'b0;
		query_bus.valid     = 1'b0;
		query_bus.data_byte = 8'h00;
		query_bus.last_byte = 1'b0;
		bytes_sent          = 0;
		burst_left          = 0;
		idle_cycles         = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_text[t]) begin
			query_bytes.delete();
			for (int i = 0; i < directed_text[t].len(); i++) begin
				query_bytes.push_back(directed_text[t][i]);
			end
			send_query();
		end
		drain();

		while (bytes_sent < BYTE_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				query_bytes.delete();
				repeat ($urandom_range(1, 8)) query_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				build_query();
				if ($urandom_range(0, 3) == 0) corrupt_query();
			end
			send_query();
			if ($urandom_range(0, 9) == 0) drain();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
